>>> hdl/wsd_pkg.sv
package wsd_pkg;

	// Number of low length bits that are counted as payload; higher bits only flag overflow.
	localparam int LENGTH_WIDTH = 32;

	// Seven-bit length codes that announce an extended length field.
	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	// Byte counts of the extended length fields and of the masking key.
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [3:0]  opcode;
		logic        fin;
		logic [2:0]  reserved_bits;
		logic        was_masked;
		logic [31:0] frame_length;
		logic        length_overflow;
		logic        empty_frame;
		logic        last;
	} wsd_result_t;

endpackage

>>> hdl/websocket_frame_deframer_core.sv
// WebSocket frame deframer with payload unmasking.
// Input channel: one raw stream byte per request on frame_byte, with byte_valid and
// byte_stall. A request is taken at a rising edge where byte_valid is high and byte_stall
// is low. Header, extended length and masking key bytes are absorbed and give no result,
// except the byte that completes the header of a frame whose counted length is zero,
// which gives one empty-frame result.
// Output channel: one result request per payload byte on result_valid and result_stall,
// with the header fields of the frame, the low 32 bits of its length, an overflow flag
// for length bits above the counted width, and a last mark.
// Each result is registered, in the output register or behind it in the skid entry.
// Throughput: one byte per cycle while byte_stall is low; the per-byte parse and unmask
// work sits between the parser state registers and the output register.
// Stalls: a two-entry output buffer (output register plus one skid entry) lets a byte be
// taken while a result waits. byte_stall rises only once the skid entry is occupied,
// which happens when a second result is due while a waiting result is stalled,
// and drops again in the cycle after the receiver takes the waiting result.
// Reset: arst_n clears the parser to expect header byte zero and empties the buffer.
module websocket_frame_deframer_core
	import wsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  frame_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  payload_byte,
	output logic [3:0]  opcode,
	output logic        fin,
	output logic [2:0]  reserved_bits,
	output logic        was_masked,
	output logic [31:0] frame_length,
	output logic        length_overflow,
	output logic        empty_frame,
	output logic        last
);

	logic        byte_take;
	logic        res_valid;
	wsd_result_t res;
	wsd_result_t out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        out_take;

	// The input is held off only while the skid entry is full, so the stall is registered.
	assign byte_stall = skid_valid_q;
	assign byte_take  = byte_valid & ~skid_valid_q;
	assign out_take   = out_valid_q & ~result_stall;

	wsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_take  (byte_take),
		.frame_byte (frame_byte),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Output buffer valid bits. A new result goes to the output register when it is free
	// or being emptied this cycle; otherwise it parks in the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers of the buffer need no reset.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign result_valid    = out_valid_q;
	assign payload_byte    = out_q.payload_byte;
	assign opcode          = out_q.opcode;
	assign fin             = out_q.fin;
	assign reserved_bits   = out_q.reserved_bits;
	assign was_masked      = out_q.was_masked;
	assign frame_length    = out_q.frame_length;
	assign length_overflow = out_q.length_overflow;
	assign empty_frame     = out_q.empty_frame;
	assign last            = out_q.last;

endmodule

>>> hdl/wsd_parser.sv
module wsd_parser
	import wsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_take,
	input  logic [7:0]  frame_byte,
	output logic        res_valid,
	output wsd_result_t res
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD
	} phase_t;

	phase_t                    phase_q, phase_d;
	logic [7:0]                hdr_q, hdr_d;
	logic                      mask_q, mask_d;
	logic [63:0]               len_q, len_d;
	logic [3:0]                cnt_q, cnt_d, cnt_dec;
	logic [31:0]               key_q, key_d;
	logic [LENGTH_WIDTH-1:0]   remain_q, remain_d;
	logic [1:0]                kpos_q, kpos_d;
	logic                      finish, emit, empty, last;
	logic [7:0]                key_byte, byte_out;

	always_comb begin
		phase_d  = phase_q;
		hdr_d    = hdr_q;
		mask_d   = mask_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		key_d    = key_q;
		remain_d = remain_q;
		kpos_d   = kpos_q;
		finish   = 1'b0;
		emit     = 1'b0;
		empty    = 1'b0;
		last     = 1'b0;
		byte_out = 8'd0;
		key_byte = 8'd0;
		cnt_dec  = cnt_q - 4'd1;
		case (phase_q)
			PH_HDR1: begin
				mask_d = frame_byte[7];
				len_d  = '0;
				if (frame_byte[6:0] == LEN_CODE_16) begin
					cnt_d   = EXT16_BYTES;
					phase_d = PH_EXTLEN;
				end else if (frame_byte[6:0] == LEN_CODE_64) begin
					cnt_d   = EXT64_BYTES;
					phase_d = PH_EXTLEN;
				end else begin
					len_d  = 64'(frame_byte[6:0]);
					finish = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_d  = {len_q[55:0], frame_byte};
				cnt_d  = cnt_dec;
				finish = (cnt_dec == 4'd0);
			end
			PH_KEY: begin
				key_d  = {key_q[23:0], frame_byte};
				cnt_d  = cnt_dec;
				finish = (cnt_dec == 4'd0);
			end
			PH_PAYLOAD: begin
				// Key byte zero sits in the top byte of the key register.
				if (mask_q) begin
					key_byte = key_q[{~kpos_q, 3'b000} +: 8];
				end
				kpos_d   = kpos_q + 2'd1;
				remain_d = remain_q - LENGTH_WIDTH'(1);
				last     = (remain_d == '0);
				emit     = 1'b1;
				byte_out = frame_byte ^ key_byte;
				if (last) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				hdr_d   = frame_byte;
				phase_d = PH_HDR1;
			end
		endcase

		// Length or key done: go to key or payload, or emit an empty-frame result.
		if (finish) begin
			if (mask_d && (phase_q != PH_KEY)) begin
				phase_d = PH_KEY;
				cnt_d   = KEY_BYTES;
				key_d   = '0;
			end else begin
				remain_d = len_d[LENGTH_WIDTH-1:0];
				kpos_d   = 2'd0;
				if (remain_d == '0) begin
					phase_d = PH_HDR0;
					emit    = 1'b1;
					empty   = 1'b1;
					last    = 1'b1;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
		end
	end

	assign res_valid           = byte_take & emit;
	assign res.payload_byte    = byte_out;
	assign res.opcode          = hdr_d[3:0];
	assign res.fin             = hdr_d[7];
	assign res.reserved_bits   = hdr_d[6:4];
	assign res.was_masked      = mask_d;
	assign res.frame_length    = len_d[31:0];
	assign res.length_overflow = |len_d[63:LENGTH_WIDTH];
	assign res.empty_frame     = empty;
	assign res.last            = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			hdr_q    <= '0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			cnt_q    <= '0;
			key_q    <= '0;
			remain_q <= '0;
			kpos_q   <= '0;
		end else if (byte_take) begin
			phase_q  <= phase_d;
			hdr_q    <= hdr_d;
			mask_q   <= mask_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			key_q    <= key_d;
			remain_q <= remain_d;
			kpos_q   <= kpos_d;
		end
	end

endmodule

>>> hdl/wsd_checker.sv
module wsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_stall,
	input logic [7:0]  frame_byte,
	input logic        result_valid,
	input logic        result_stall,
	input logic [7:0]  payload_byte,
	input logic [3:0]  opcode,
	input logic        fin,
	input logic [2:0]  reserved_bits,
	input logic        was_masked,
	input logic [31:0] frame_length,
	input logic        length_overflow,
	input logic        empty_frame,
	input logic        last
);

	// A stalled result stays valid.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(payload_byte) && $stable(last)
			&& $stable(empty_frame) && $stable(frame_length) && $stable(opcode)
			&& $stable(fin) && $stable(reserved_bits) && $stable(was_masked)
			&& $stable(length_overflow))
		else $error("result changed while stalled");

	// A stalled input request stays offered with the same byte.
	a_input_holds: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(frame_byte))
		else $error("input request changed while stalled");

	// A fresh result always follows a byte taken in the cycle before.
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && !byte_stall))
		else $error("result without a byte taken");

	// The input is held off only after the result side was stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> $past(result_valid && result_stall))
		else $error("input stalled without output backpressure");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (.*);

>>> tb/sv/tb_websocket_frame_deframer_core.sv
module tb_websocket_frame_deframer_core;
	import wsd_pkg::*;

	// The run is short; this cap only catches a hung handshake.
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 10;
	localparam int HOLD_OFF_CYCLES = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  frame_byte = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  payload_byte;
	logic [3:0]  opcode;
	logic        fin;
	logic [2:0]  reserved_bits;
	logic        was_masked;
	logic [31:0] frame_length;
	logic        length_overflow;
	logic        empty_frame;
	logic        last;

	websocket_frame_deframer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.frame_byte(frame_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.payload_byte(payload_byte),
		.opcode(opcode),
		.fin(fin),
		.reserved_bits(reserved_bits),
		.was_masked(was_masked),
		.frame_length(frame_length),
		.length_overflow(length_overflow),
		.empty_frame(empty_frame),
		.last(last)
	);

	always #4 clk = ~clk;

	// How the payload length of a generated frame is encoded in its header.
	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

	// Parser position of the predictor, one value per kind of byte it expects next.
	typedef enum logic [2:0] {
		HDR0_WAIT,
		HDR1_WAIT,
		EXT_LEN_READ,
		KEY_READ,
		PAYLOAD_PASS
	} parse_e;

	// Predictor state. It mirrors what the block must remember between bytes.
	parse_e      parse_q = HDR0_WAIT;
	logic [7:0]  hdr0_q = 8'h00;
	logic        mask_q = 1'b0;
	logic [63:0] len_q = '0;
	logic [3:0]  hdr_left = '0;
	logic [31:0] key_q = '0;
	logic [63:0] remaining_q = '0;
	logic [1:0]  key_pos = '0;

	// Results the block still owes, oldest first.
	wsd_result_t pending_results[$];

	// Stimulus shaping. Source idle applies per request, sink idle to every stall draw.
	// Once the hold-off is started, the result channel stalls until its counter runs out.
	int source_idle_pct = 35;
	int sink_idle_pct = 35;
	bit hold_off_go = 1'b0;
	bit hold_off_done = 1'b0;
	int hold_off_count = 0;

	int cycle_count = 0;
	int error_count = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int results_checked = 0;
	int empty_results = 0;
	int overflow_results = 0;
	int input_stall_cycles = 0;

	// Builds one result from the header fields of the frame in progress.
	function automatic wsd_result_t frame_result(input logic [7:0] data, input logic is_empty,
		input logic is_last);
		wsd_result_t r;
		r.payload_byte = data;
		r.opcode = hdr0_q[3:0];
		r.fin = hdr0_q[7];
		r.reserved_bits = hdr0_q[6:4];
		r.was_masked = mask_q;
		r.frame_length = len_q[31:0];
		r.length_overflow = (len_q >> LENGTH_WIDTH) != 64'd0;
		r.empty_frame = is_empty;
		r.last = is_last;
		return r;
	endfunction

	// Runs once the length is complete and again once the key is complete. A masked
	// frame first detours through the key bytes. A frame whose counted length is zero
	// ends right here with its empty-frame result.
	function automatic bit close_header(output wsd_result_t r);
		r = '0;
		if (mask_q && parse_q != KEY_READ) begin
			parse_q = KEY_READ;
			hdr_left = KEY_BYTES;
			key_q = '0;
			return 1'b0;
		end
		remaining_q = len_q & ((64'd1 << LENGTH_WIDTH) - 64'd1);
		key_pos = '0;
		if (remaining_q == 64'd0) begin
			parse_q = HDR0_WAIT;
			r = frame_result(8'h00, 1'b1, 1'b1);
			return 1'b1;
		end
		parse_q = PAYLOAD_PASS;
		return 1'b0;
	endfunction

	// Advances the predictor by one accepted stream byte; returns 1 when a result is due.
	function automatic bit deframe_byte(input logic [7:0] b, output wsd_result_t r);
		logic [7:0] key_byte;
		bit produced;
		r = '0;
		produced = 1'b0;
		case (parse_q)
			HDR1_WAIT: begin
				mask_q = b[7];
				len_q = '0;
				if (b[6:0] == LEN_CODE_16) begin
					hdr_left = EXT16_BYTES;
					parse_q = EXT_LEN_READ;
				end else if (b[6:0] == LEN_CODE_64) begin
					hdr_left = EXT64_BYTES;
					parse_q = EXT_LEN_READ;
				end else begin
					len_q = 64'(b[6:0]);
					produced = close_header(r);
				end
			end
			EXT_LEN_READ: begin
				len_q = {len_q[55:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == 4'd0)
					produced = close_header(r);
			end
			KEY_READ: begin
				key_q = {key_q[23:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == 4'd0)
					produced = close_header(r);
			end
			PAYLOAD_PASS: begin
				key_byte = mask_q ? 8'(key_q >> (24 - 8 * key_pos)) : 8'h00;
				key_pos = key_pos + 2'd1;
				remaining_q = remaining_q - 64'd1;
				r = frame_result(b ^ key_byte, 1'b0, remaining_q == 64'd0);
				produced = 1'b1;
				if (remaining_q == 64'd0)
					parse_q = HDR0_WAIT;
			end
			default: begin
				hdr0_q = b;
				parse_q = HDR1_WAIT;
			end
		endcase
		return produced;
	endfunction

	// Offers one stream byte as a request, with random idle cycles ahead of it, and
	// records what the block owes for it once it is taken.
	task automatic send_byte(input logic [7:0] b);
		wsd_result_t r;
		while (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		frame_byte <= b;
		@(posedge clk);
		while (byte_stall !== 1'b0) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		bytes_sent++;
		if (deframe_byte(b, r))
			pending_results.push_back(r);
	endtask

	// Sends one complete frame. A negative fill draws every payload byte at random.
	task automatic send_frame(input logic [7:0] hdr0, input logic masked, input len_form_e form,
		input logic [63:0] length, input logic [31:0] key, input int fill);
		logic [63:0] counted;
		counted = length & ((64'd1 << LENGTH_WIDTH) - 64'd1);
		send_byte(hdr0);
		case (form)
			LEN_EXT16: begin
				send_byte({masked, LEN_CODE_16});
				send_byte(length[15:8]);
				send_byte(length[7:0]);
			end
			LEN_EXT64: begin
				send_byte({masked, LEN_CODE_64});
				for (int i = 7; i >= 0; i--)
					send_byte(8'(length >> (8 * i)));
			end
			default: send_byte({masked, length[6:0]});
		endcase
		if (masked) begin
			for (int i = 3; i >= 0; i--)
				send_byte(8'(key >> (8 * i)));
		end
		for (longint unsigned i = 0; i < counted; i++)
			send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
		frames_sent++;
	endtask

	// One field of a result against its expectation.
	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got === want)
			return;
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("result %0d: %s expected 0x%0h, got 0x%0h", results_checked, name, want,
				got);
	endfunction

	// Result channel: checks every taken result, then decides the stall for the next cycle.
	// Values read here are those from before the edge, since the block and this process
	// only update through nonblocking assignments.
	always @(posedge clk) begin
		wsd_result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("unexpected result: payload_byte 0x%0h, empty_frame %b, last %b",
						payload_byte, empty_frame, last);
			end else begin
				want = pending_results.pop_front();
				check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
				check_field("opcode", 32'(want.opcode), 32'(opcode));
				check_field("fin", 32'(want.fin), 32'(fin));
				check_field("reserved_bits", 32'(want.reserved_bits), 32'(reserved_bits));
				check_field("was_masked", 32'(want.was_masked), 32'(was_masked));
				check_field("frame_length", want.frame_length, frame_length);
				check_field("length_overflow", 32'(want.length_overflow),
					32'(length_overflow));
				check_field("empty_frame", 32'(want.empty_frame), 32'(empty_frame));
				check_field("last", 32'(want.last), 32'(last));
				if (want.empty_frame)
					empty_results++;
				if (want.length_overflow)
					overflow_results++;
			end
			results_checked++;
		end
		result_stall <= (hold_off_go && !hold_off_done) ||
			(sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct);
	end

	// The long hold-off of the result channel is counted here, one cycle at a time.
	always @(posedge clk) begin
		if (hold_off_go && !hold_off_done) begin
			hold_off_count <= hold_off_count + 1;
			if (hold_off_count == HOLD_OFF_CYCLES - 1)
				hold_off_done <= 1'b1;
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				pending_results.size());
			$display("websocket_frame_deframer_core test failed");
			$finish;
		end
	end

	// Short hand-picked frames: every opcode as a zero-length frame, the extreme header
	// and payload bytes, a masked zero-length frame (the key still has to be read), a
	// key that wraps across payload bytes, a non-minimal 16-bit length of zero, and
	// 64-bit lengths with upper bits set, both with a zero and a nonzero counted length.
	task automatic test_directed_frames();
		for (int op = 0; op < 16; op++)
			send_frame({op[0], op[2:0], op[3:0]}, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
		send_frame(8'hFF, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
		send_frame(8'h00, 1'b1, LEN_SHORT, 64'd5, 32'hA55A_FF00, 8'hFF);
		send_frame(8'h82, 1'b0, LEN_EXT16, 64'd0, 32'h0, 0);
		send_frame(8'h89, 1'b0, LEN_EXT16, 64'd2, 32'h0, 8'h00);
		send_frame(8'h81, 1'b1, LEN_EXT64, 64'hFFFF_FFFF_0000_0000, 32'h1234_5678, 0);
		send_frame(8'h02, 1'b0, LEN_EXT64, 64'h8000_0000_0000_0001, 32'h0, 8'hFF);
	endtask

	// Well-formed frames with random header byte zero (any opcode, RSV bits and FIN), a
	// random mask flag and key, and lengths spread over all three encodings. Counted
	// lengths are kept modest so that many frames fit in the byte budget.
	task automatic test_random_frames(input int byte_budget);
		int stop_at;
		int pick;
		len_form_e form;
		logic [63:0] length;
		logic [31:0] key;
		stop_at = bytes_sent + byte_budget;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				form = LEN_SHORT;
				length = ($urandom_range(9) == 0) ? 64'd0 : 64'($urandom_range(1, 20));
			end else if (pick < 65) begin
				form = LEN_SHORT;
				length = 64'($urandom_range(100, 125));
			end else if (pick < 85) begin
				form = LEN_EXT16;
				length = ($urandom_range(5) == 0) ? 64'd0 : 64'($urandom_range(1, 300));
			end else begin
				form = LEN_EXT64;
				length = {($urandom_range(2) == 0) ? 32'h0 : 32'($urandom),
					32'($urandom_range(0, 12))};
			end
			key = ($urandom_range(7) == 0) ? 32'h0 : 32'($urandom);
			send_frame(8'($urandom), 1'($urandom), form, length, key, -1);
		end
	endtask

	// Back-to-back traffic with neither side idling, so that a result can leave on
	// every cycle.
	task automatic test_quiet_stretch(input int byte_budget);
		source_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_frames(byte_budget);
		source_idle_pct = 35;
		sink_idle_pct = 35;
	endtask

	// The receiver holds off for a long time while the sender keeps offering payload,
	// so the output buffer fills and the block must stall its input without losing or
	// repeating a byte.
	task automatic test_output_hold_off();
		source_idle_pct = 0;
		hold_off_go <= 1'b1;
		send_frame(8'h82, 1'b1, LEN_SHORT, 64'd80, 32'hDEAD_BEEF, -1);
		source_idle_pct = 35;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_random_frames(700);
		test_quiet_stretch(300);
		test_output_hold_off();
		test_random_frames(100);

		byte_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// Wait on so that any stray result after the last one still shows up.
		repeat (20) @(posedge clk);

		$display("Sent %0d frames in %0d stream bytes; checked %0d results, %0d empty frames",
			frames_sent, bytes_sent, results_checked, empty_results);
		$display("and %0d with length overflow; input held back on %0d cycles.",
			overflow_results, input_stall_cycles);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("websocket_frame_deframer_core test passed");
		end else begin
			$display("%0d mismatches, %0d results never arrived", error_count,
				pending_results.size());
			$display("websocket_frame_deframer_core test failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/wsd_pkg.sv
hdl/wsd_parser.sv
hdl/websocket_frame_deframer_core.sv
hdl/wsd_checker.sv
tb/sv/tb_websocket_frame_deframer_core.sv
